>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue block.
// Holds the beat structs, operation and status codes, and controller types.
// Depends on nothing; every other file imports it.
package deq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned ValueW           = 32;
  localparam int unsigned CountW           = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_LOAD = 2'd3
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [ValueW-1:0]  value;
  } deq_in_t;

  typedef struct packed {
    status_e            status;
    logic [ValueW-1:0]  front_value;
    logic [ValueW-1:0]  back_value;
    logic [CountW-1:0]  count;
    logic               empty_flag;
  } deq_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } deq_cmd_t;

  typedef struct packed {
    logic out_free;
  } deq_stat_t;

endpackage

>>> rtl/double_ended_queue_core.sv
// Top level of the double-ended queue block.
// Instantiates deq_ctrl and deq_dpath; depends on deq_pkg.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one operation
// per beat: push front, push back, pop front or pop back, with a data word.
// The output channel (out_valid_o, out_stall_i, out_data_o) returns exactly
// one result beat per operation: a status, the front and back words, the
// count and an empty flag.
// One operation is worked on at a time. After an input beat is taken the
// block first updates the head, count and slot memory, then reads the front
// and back slots through the registered memory ports, and then loads the
// result register, from which the result is presented. A new input beat is
// taken only once the result of the last one has been loaded; this order is
// set by the write followed by the registered dual read of the slot memory.
// The next input beat is taken while a result still waits in the output
// register; a stall on the output holds the result and, once the following
// operation reaches its load step, holds the controller there as well.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = deq_pkg::DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  deq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/deq_ctrl.sv
// Controller state machine for the double-ended queue.
// Sequences capture, update, read and result load; depends on deq_pkg.
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_cmd_t  cmd_o,
  output logic               in_stall_o
);
  import deq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_READ: cmd_o.read = 1'b1;
      S_LOAD: cmd_o.load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/deq_dpath.sv
// Datapath for the double-ended queue: slot memory, head and count
// registers, read registers and the result register. Depends on deq_pkg.
module deq_dpath #(
  parameter int unsigned DEPTH      = deq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = deq_pkg::DataWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  deq_pkg::deq_cmd_t  cmd_i,
  input  deq_pkg::deq_in_t   in_data_i,
  input  logic               out_stall_i,
  output deq_pkg::deq_stat_t stat_o,
  output logic               out_valid_o,
  output deq_pkg::deq_out_t  out_data_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  func_e                 func_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [IdxW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;
  deq_out_t              out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [SumW-1:0] tail_sum, tail_wrap;
  logic [IdxW-1:0] tail_idx, back_idx, head_prev, head_next;
  logic            is_full, q_empty;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  assign is_full = (count_q == CntW'(DEPTH));
  assign q_empty = (count_q == '0);

  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail_wrap = (tail_sum >= SumW'(DEPTH)) ? (tail_sum - SumW'(DEPTH)) : tail_sum;
  assign tail_idx  = tail_wrap[IdxW-1:0];
  assign back_idx  = (tail_idx == '0) ? IdxW'(DEPTH - 1) : (tail_idx - IdxW'(1));
  assign head_prev = (head_q == '0) ? IdxW'(DEPTH - 1) : (head_q - IdxW'(1));
  assign head_next = (head_q == IdxW'(DEPTH - 1)) ? '0 : (head_q + IdxW'(1));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = tail_idx;
    if (cmd_i.exec) begin
      unique case (func_q)
        FUNC_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
            head_d   = head_prev;
            wr_en    = 1'b1;
            wr_addr  = head_prev;
            count_d  = count_q + CntW'(1);
          end
        end
        FUNC_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
            wr_en    = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        FUNC_POP_FRONT: begin
          if (q_empty) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_OK;
            head_d   = head_next;
            count_d  = count_q - CntW'(1);
          end
        end
        FUNC_POP_BACK: begin
          if (q_empty) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_OK;
            count_d  = count_q - CntW'(1);
          end
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
    if (cmd_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_back_q  <= mem_q[back_idx];
    end
    if (cmd_i.capture) begin
      func_q  <= in_data_i.func;
      value_q <= DATA_WIDTH'(in_data_i.value);
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      out_valid_d       = 1'b1;
      out_d.status      = status_q;
      out_d.front_value = q_empty ? '0 : ValueW'(rd_front_q);
      out_d.back_value  = q_empty ? '0 : ValueW'(rd_back_q);
      out_d.count       = CountW'(count_q);
      out_d.empty_flag  = q_empty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core.
module deq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input deq_pkg::deq_in_t  in_data_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input deq_pkg::deq_out_t out_data_i
);
  import deq_pkg::*;

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_i;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_i)
    else $error("input beat taken while an operation is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed or dropped");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.empty_flag |->
      out_data_i.front_value == '0 && out_data_i.back_value == '0 &&
      out_data_i.count == '0)
    else $error("empty result carries nonzero fields");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_beat, 4))
    else $error("result beat not four cycles after its input beat");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

>>> sim/deq_checker.sv
`timescale 1ns / 100ps
// Result checker for the double-ended queue: watches both channels, keeps a shadow
// deque, and compares every result beat with the oldest predicted one.
// Depends on deq_pkg for the beat structs and the operation and status codes.
module deq_scoreboard
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  deq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  deq_out_t out_data_i,
  output int       err_cnt_o,
  output int       pending_o,
  output int       checked_o,
  output int       rejects_o
);

  localparam int unsigned Depth = DepthDefault;

  logic [ValueW-1:0] shadow_slots [Depth];
  logic [3:0]        shadow_head;
  logic [CountW-1:0] shadow_fill;
  deq_out_t          expected_results [$];
  deq_out_t          want;
  int                errs;
  int                checked;
  int                rejects;

  function automatic deq_out_t next_deque_result(deq_in_t op);
    deq_out_t   res;
    logic [3:0] pos;
    res = '0;
    res.status = ST_OK;
    case (op.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (shadow_fill >= CountW'(Depth)) begin
          res.status = ST_FULL;
        end else if (op.func == FUNC_PUSH_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = op.value;
          shadow_fill = shadow_fill + CountW'(1);
        end else begin
          pos = shadow_head + shadow_fill[3:0];
          shadow_slots[pos] = op.value;
          shadow_fill = shadow_fill + CountW'(1);
        end
      end
      default: begin
        if (shadow_fill == '0) begin
          res.status = ST_EMPTY;
        end else if (op.func == FUNC_POP_FRONT) begin
          shadow_head = shadow_head + 4'd1;
          shadow_fill = shadow_fill - CountW'(1);
        end else begin
          shadow_fill = shadow_fill - CountW'(1);
        end
      end
    endcase
    res.count = shadow_fill;
    res.empty_flag = (shadow_fill == '0);
    if (shadow_fill != '0) begin
      pos = shadow_head + shadow_fill[3:0] - 4'd1;
      res.front_value = shadow_slots[shadow_head];
      res.back_value = shadow_slots[pos];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_head = '0;
      shadow_fill = '0;
      expected_results.delete();
      errs = 0;
      checked = 0;
      rejects = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      rejects_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.insert(expected_results.size(), next_deque_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("ERROR: result beat with nothing expected: status %0d front %h back %h",
                     out_data_i.status, out_data_i.front_value, out_data_i.back_value);
          end
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          checked++;
          if (want.status != ST_OK) begin
            rejects++;
          end
          if (out_data_i.status !== want.status ||
              out_data_i.front_value !== want.front_value ||
              out_data_i.back_value !== want.back_value ||
              out_data_i.count !== want.count ||
              out_data_i.empty_flag !== want.empty_flag) begin
            errs++;
            if (errs <= 10) begin
              $display("ERROR: result %0d expected st %0d front %h back %h cnt %0d empty %0b",
                       checked, want.status, want.front_value, want.back_value,
                       want.count, want.empty_flag);
              $display("       got      st %0d front %h back %h cnt %0d empty %0b",
                       out_data_i.status, out_data_i.front_value, out_data_i.back_value,
                       out_data_i.count, out_data_i.empty_flag);
            end
          end
        end
      end
      err_cnt_o <= errs;
      pending_o <= expected_results.size();
      checked_o <= checked;
      rejects_o <= rejects;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset, operation stimulus and
// receiver stalls, with deq_scoreboard doing prediction. Depends on deq_pkg and the RTL.
module tb_top;
  import deq_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 113;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  deq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  deq_out_t out_data;

  int err_cnt;
  int pending;
  int checked;
  int rejects;
  int sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #10 clk = ~clk;

  double_ended_queue_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  deq_scoreboard u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .rejects_o  (rejects)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_op(input func_e f, input logic [ValueW-1:0] v);
    deq_in_t beat;
    beat.func = f;
    beat.value = v;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  initial begin
    int push_pct;
    int pick;
    func_e f;
    logic [ValueW-1:0] v;
    int send_modes [4];
    int stall_modes [4];
    send_modes = '{0, 49, 0, 28};
    stall_modes = '{0, 0, 49, 28};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: pops on empty, a single-word pop, fill with wrap, pushes on full, pops from full.
    send_op(FUNC_POP_FRONT, 32'h0000_0000);
    send_op(FUNC_POP_BACK, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(FUNC_POP_BACK, 32'h0000_0000);
    send_op(FUNC_PUSH_BACK, 32'h0000_0000);
    send_op(FUNC_POP_FRONT, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      send_op(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
              (i[1] ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A) ^ {i[3:0], 24'h0, i[3:0]});
    end
    send_op(FUNC_PUSH_FRONT, 32'h1234_5678);
    send_op(FUNC_PUSH_BACK, 32'h8765_4321);
    send_op(FUNC_POP_FRONT, 32'h0000_0000);
    send_op(FUNC_POP_BACK, 32'h0000_0000);

    push_pct = 50;
    for (int p = 0; p < 4; p++) begin
      // The sender holds off until every outstanding result has been returned.
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      send_idle_pct = send_modes[p];
      stall_pct = stall_modes[p];
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 30 == 0) begin
          pick = $urandom_range(2, 0);
          push_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
        end
        if ($urandom_range(99, 0) < push_pct) begin
          f = $urandom_range(1, 0) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
        end else begin
          f = $urandom_range(1, 0) ? FUNC_POP_BACK : FUNC_POP_FRONT;
        end
        pick = $urandom_range(7, 0);
        v = (pick == 0) ? '0 : (pick == 1) ? '1 : ValueW'($urandom);
        send_op(f, v);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Summary: %0d operations sent, directed then four random idle/stall phases.",
             sent);
    $display("Summary: %0d results compared, %0d of them full or empty rejections.",
             checked, rejects);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dpath.sv
rtl/double_ended_queue_core.sv
rtl/deq_checker.sv
sim/deq_checker.sv
sim/tb_top.sv
